// File: hdl/assert_macros.svh
// Assertion macros shared by the memory block RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define VMEG_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle.
`define VMEG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/vmeg_pkg.sv
// Shared types, constants and byte rotation functions for the VM memory block.
package vmeg_pkg;

  localparam int unsigned BANKS      = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = BANKS * BYTE_W;
  localparam int unsigned LANE_W     = 64;
  localparam int unsigned LANES      = 4;
  localparam int unsigned OFF_W      = 64;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned GAS_W      = 14;
  localparam int unsigned SIZE_W     = 12;
  localparam int unsigned GAS_FACTOR = 3;
  localparam int unsigned QUAD_SHIFT = 9;

  typedef enum logic [1:0] {
    KIND_RD_BYTE = 2'd0,
    KIND_WR_BYTE = 2'd1,
    KIND_RD_WORD = 2'd2,
    KIND_WR_WORD = 2'd3
  } kind_t;

  function automatic logic [WORD_W-1:0] rotl_bytes(logic [WORD_W-1:0] v,
                                                   logic [SHIFT_W-1:0] s);
    logic [WORD_W-1:0] t;
    t = v;
    for (int k = 0; k < SHIFT_W; k++) begin
      if (s[k]) begin
        t = (t << (BYTE_W << k)) | (t >> (WORD_W - (BYTE_W << k)));
      end
    end
    return t;
  endfunction

  function automatic logic [WORD_W-1:0] rotr_bytes(logic [WORD_W-1:0] v,
                                                   logic [SHIFT_W-1:0] s);
    logic [WORD_W-1:0] t;
    t = v;
    for (int k = 0; k < SHIFT_W; k++) begin
      if (s[k]) begin
        t = (t >> (BYTE_W << k)) | (t << (WORD_W - (BYTE_W << k)));
      end
    end
    return t;
  endfunction

  function automatic logic [WORD_W-1:0] rev_bytes(logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] t;
    for (int i = 0; i < BANKS; i++) begin
      t[BYTE_W*i +: BYTE_W] = v[WORD_W-BYTE_W*(i+1) +: BYTE_W];
    end
    return t;
  endfunction

endpackage

// File: hdl/vmeg_bank.sv
// One byte-wide bank of the store with a registered read port.
module vmeg_bank
  import vmeg_pkg::*;
#(
  parameter int unsigned ROWS = 2048,
  parameter int unsigned RW   = 11
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [RW-1:0]     row,
  input  logic [BYTE_W-1:0] wdata,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [ROWS];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[row] <= wdata;
      end
      rdata_r <= mem[row];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/vmeg_merge.sv
// Realigns the bank bytes into big-endian read lanes.
module vmeg_merge
  import vmeg_pkg::*;
(
  input  logic                        ok,
  input  kind_t                       kind,
  input  logic [SHIFT_W-1:0]          shift,
  input  logic [WORD_W-1:0]           bank_bytes,
  output logic [LANES-1:0][LANE_W-1:0] lanes
);

  logic [WORD_W-1:0] ordered;

  assign ordered = rotr_bytes(bank_bytes, shift);

  always_comb begin
    lanes = '0;
    if (ok) begin
      case (kind)
        KIND_RD_BYTE: lanes[0] = {{(LANE_W-BYTE_W){1'b0}}, ordered[BYTE_W-1:0]};
        KIND_RD_WORD: lanes = rev_bytes(ordered);
        default:      lanes = '0;
      endcase
    end
  end

endmodule

// File: hdl/vm_memory_with_expansion_gas.sv
// Top level of the byte-addressed VM memory with expansion gas accounting.
// One access is handled at a time. After acceptance, the evaluation state
// checks the bounds and runs the registered read of the 32 byte banks along
// with the size square; the merge state then realigns the bytes, settles the
// gas and loads the result register. A new access is accepted in the cycle
// after the result is loaded, even while that result still waits to be taken;
// a result that is not taken holds the next access in the merge state. The
// store is split into 32 byte banks, so an unaligned word touches each bank
// once. After reset the block writes zeros to every row of the banks
// (MEM_BYTES/32 rows, 2048 by default), and in_ready stays low until that
// pass is done.
`include "assert_macros.svh"

module vm_memory_with_expansion_gas
  import vmeg_pkg::*;
#(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [OFF_W-1:0]  in_offset,
  input  logic [LANE_W-1:0] in_data_lane0,
  input  logic [LANE_W-1:0] in_data_lane1,
  input  logic [LANE_W-1:0] in_data_lane2,
  input  logic [LANE_W-1:0] in_data_lane3,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_ok,
  output logic [LANE_W-1:0] out_read_lane0,
  output logic [LANE_W-1:0] out_read_lane1,
  output logic [LANE_W-1:0] out_read_lane2,
  output logic [LANE_W-1:0] out_read_lane3,
  output logic [GAS_W-1:0]  out_expansion_gas,
  output logic [SIZE_W-1:0] out_size_in_words
);

  localparam int unsigned ROWS  = MEM_BYTES / BANKS;
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned UW    = $clog2(ROWS + 1);
  localparam int unsigned NW_W  = OFF_W - SHIFT_W + 1;
  localparam int unsigned CALC_W = 2 * UW + 2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_MERGE
  } state_t;

  state_t                        state_r;
  logic [RW-1:0]                 clr_row_r;
  kind_t                         kind_r;
  logic [OFF_W-1:0]              offset_r;
  logic [LANES-1:0][LANE_W-1:0]  wlanes_r;
  logic                          ok_r;
  logic                          grow_r;
  logic [UW-1:0]                 nw_r;
  logic [2*UW-1:0]               sq_r;
  logic [UW-1:0]                 used_r;
  logic [GAS_W-1:0]              cost_r;
  logic                          out_valid_r;
  logic                          out_ok_r;
  logic [LANES-1:0][LANE_W-1:0]  out_lanes_r;
  logic [GAS_W-1:0]              out_gas_r;

  logic [OFF_W:0]                acc_end;
  logic [NW_W-1:0]               nw_wide;
  logic                          ok_c;
  logic                          is_word;
  logic                          is_write;
  logic                          clearing;
  logic [SHIFT_W-1:0]            shift_c;
  logic [RW-1:0]                 base_row;
  logic [WORD_W-1:0]             wr_le;
  logic [WORD_W-1:0]             wr_banks;
  logic [WORD_W-1:0]             rd_banks;
  logic [BANKS-1:0]              bank_en;
  logic [LANES-1:0][LANE_W-1:0]  rd_lanes;
  logic [CALC_W-1:0]             cost_calc;
  logic [GAS_W-1:0]              cost_new;
  logic                          load_out;

  assign is_word  = (kind_r == KIND_RD_WORD) || (kind_r == KIND_WR_WORD);
  assign is_write = (kind_r == KIND_WR_BYTE) || (kind_r == KIND_WR_WORD);
  assign clearing = (state_r == S_CLEAR);
  assign shift_c  = offset_r[SHIFT_W-1:0];
  assign base_row = offset_r[SHIFT_W +: RW];

  assign acc_end = {1'b0, offset_r} + (is_word ? (OFF_W+1)'(BANKS) : (OFF_W+1)'(1));
  assign nw_wide = NW_W'(acc_end[OFF_W-1:SHIFT_W]) + NW_W'(|acc_end[SHIFT_W-1:0]);
  assign ok_c    = !acc_end[OFF_W] && (nw_wide <= NW_W'(ROWS));

  assign wr_le    = is_word ? rev_bytes(wlanes_r)
                            : {{(WORD_W-BYTE_W){1'b0}}, wlanes_r[0][BYTE_W-1:0]};
  assign wr_banks = rotl_bytes(wr_le, shift_c);

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [RW-1:0] row_b;

    assign row_b = base_row + RW'(SHIFT_W'(b) < shift_c);
    assign bank_en[b] = (state_r == S_EVAL) && ok_c && (is_word || (SHIFT_W'(b) == shift_c));

    vmeg_bank #(
      .ROWS (ROWS),
      .RW   (RW)
    ) u_bank (
      .clk   (clk),
      .en    (bank_en[b] || clearing),
      .we    (is_write || clearing),
      .row   (clearing ? clr_row_r : row_b),
      .wdata (clearing ? '0 : wr_banks[BYTE_W*b +: BYTE_W]),
      .rdata (rd_banks[BYTE_W*b +: BYTE_W])
    );
  end

  vmeg_merge u_merge (
    .ok         (ok_r),
    .kind       (kind_r),
    .shift      (shift_c),
    .bank_bytes (rd_banks),
    .lanes      (rd_lanes)
  );

  assign cost_calc = CALC_W'(GAS_FACTOR) * CALC_W'(nw_r) + CALC_W'(sq_r >> QUAD_SHIFT);
  assign cost_new  = cost_calc[GAS_W-1:0];
  assign load_out  = (state_r == S_MERGE) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_row_r   <= '0;
      used_r      <= '0;
      cost_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_row_r <= clr_row_r + RW'(1);
          if (clr_row_r == RW'(ROWS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          state_r <= S_MERGE;
        end
        S_MERGE: begin
          if (load_out) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= ok_r;
            out_lanes_r <= rd_lanes;
            out_gas_r   <= (ok_r && grow_r) ? GAS_W'(cost_new - cost_r) : '0;
            state_r     <= S_IDLE;
            if (ok_r && grow_r) begin
              used_r <= nw_r;
              cost_r <= cost_new;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r      <= kind_t'(in_kind);
      offset_r    <= in_offset;
      wlanes_r[0] <= in_data_lane0;
      wlanes_r[1] <= in_data_lane1;
      wlanes_r[2] <= in_data_lane2;
      wlanes_r[3] <= in_data_lane3;
    end
    if (state_r == S_EVAL) begin
      ok_r   <= ok_c;
      nw_r   <= UW'(nw_wide);
      grow_r <= UW'(nw_wide) > used_r;
      sq_r   <= (2*UW)'(UW'(nw_wide)) * (2*UW)'(UW'(nw_wide));
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_read_lane0    = out_lanes_r[0];
  assign out_read_lane1    = out_lanes_r[1];
  assign out_read_lane2    = out_lanes_r[2];
  assign out_read_lane3    = out_lanes_r[3];
  assign out_expansion_gas = out_gas_r;
  assign out_size_in_words = SIZE_W'(used_r);

  `VMEG_ASSERT(a_size_bound, used_r <= UW'(ROWS), "Memory size exceeds the built store.")
  `VMEG_ASSERT_IMP(a_refused_quiet, out_valid_r && !out_ok_r, out_gas_r == '0 && out_lanes_r == '0, "Refused access carries data or gas.")
  `VMEG_ASSERT_IMP(a_bank_idle, state_r != S_EVAL, bank_en == '0, "Bank access outside the evaluation cycle.")

endmodule

// File: dv/vmeg_checker.sv
// Checker that predicts each memory access result and compares the words taken from the block.
module vmeg_checker
  import vmeg_pkg::*;
#(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [OFF_W-1:0]  in_offset,
  input  logic [LANE_W-1:0] in_data_lane0,
  input  logic [LANE_W-1:0] in_data_lane1,
  input  logic [LANE_W-1:0] in_data_lane2,
  input  logic [LANE_W-1:0] in_data_lane3,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_ok,
  input  logic [LANE_W-1:0] out_read_lane0,
  input  logic [LANE_W-1:0] out_read_lane1,
  input  logic [LANE_W-1:0] out_read_lane2,
  input  logic [LANE_W-1:0] out_read_lane3,
  input  logic [GAS_W-1:0]  out_expansion_gas,
  input  logic [SIZE_W-1:0] out_size_in_words,
  output int                mismatch_total,
  output int                accesses_in_flight
);

  localparam int unsigned MAX_WORDS = MEM_BYTES / BANKS;

  typedef struct packed {
    logic                          ok;
    logic [LANES-1:0][LANE_W-1:0]  lane;
    logic [GAS_W-1:0]              gas;
    logic [SIZE_W-1:0]             size;
  } access_result_t;

  logic [BYTE_W-1:0]            mem_image [MEM_BYTES];
  logic [63:0]                  used_words;
  access_result_t               predicted_results [$];
  access_result_t               want;
  access_result_t               fresh;
  logic [LANES-1:0][LANE_W-1:0] seen_lanes;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("mismatch in %s: got %h, want %h", what, got, exp_val);
    mismatch_total++;
  endtask

  function automatic logic [63:0] word_cost(input logic [63:0] w);
    return GAS_FACTOR * w + ((w * w) >> QUAD_SHIFT);
  endfunction

  task automatic predict_access(input logic [1:0] kind_bits, input logic [63:0] off,
                                input logic [LANES-1:0][LANE_W-1:0] data,
                                output access_result_t res);
    logic [64:0]       end_addr;
    logic [64:0]       new_words;
    logic [WORD_W-1:0] word;
    logic [63:0]       gas;
    int unsigned       base;
    kind_t             kind;
    res  = '0;
    gas  = '0;
    word = '0;
    kind = kind_t'(kind_bits);
    end_addr = {1'b0, off} +
               ((kind == KIND_RD_WORD || kind == KIND_WR_WORD) ? 65'd32 : 65'd1);
    if (!end_addr[64]) begin
      new_words = (end_addr >> SHIFT_W) + ((end_addr[SHIFT_W-1:0] != '0) ? 65'd1 : 65'd0);
      if (new_words <= MAX_WORDS) begin
        if (new_words > used_words) begin
          gas = word_cost(new_words[63:0]) - word_cost(used_words);
          used_words = new_words[63:0];
        end
        res.ok = 1'b1;
        base = off[31:0];
        case (kind)
          KIND_RD_BYTE: begin
            res.lane[0] = {{(LANE_W-BYTE_W){1'b0}}, mem_image[base]};
          end
          KIND_WR_BYTE: begin
            mem_image[base] = data[0][BYTE_W-1:0];
          end
          KIND_RD_WORD: begin
            for (int i = 0; i < BANKS; i++) begin
              word[WORD_W-1-BYTE_W*i -: BYTE_W] = mem_image[base+i];
            end
            res.lane = word;
          end
          KIND_WR_WORD: begin
            word = data;
            for (int i = 0; i < BANKS; i++) begin
              mem_image[base+i] = word[WORD_W-1-BYTE_W*i -: BYTE_W];
            end
          end
          default: ;
        endcase
      end
    end
    res.gas  = gas[GAS_W-1:0];
    res.size = used_words[SIZE_W-1:0];
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      predicted_results.delete();
      used_words = '0;
      foreach (mem_image[a]) mem_image[a] = '0;
      mismatch_total = 0;
      accesses_in_flight <= 0;
    end else begin
      if (out_valid && out_ready) begin
        seen_lanes = {out_read_lane3, out_read_lane2, out_read_lane1, out_read_lane0};
        if (predicted_results.size() == 0) begin
          report_mismatch("word with no access waiting", out_read_lane0, '0);
        end else begin
          want = predicted_results.pop_front();
          if (out_ok !== want.ok) report_mismatch("ok", out_ok, want.ok);
          for (int i = 0; i < LANES; i++) begin
            if (seen_lanes[i] !== want.lane[i]) begin
              report_mismatch($sformatf("read_lane%0d", i), seen_lanes[i], want.lane[i]);
            end
          end
          if (out_expansion_gas !== want.gas) begin
            report_mismatch("expansion_gas", out_expansion_gas, want.gas);
          end
          if (out_size_in_words !== want.size) begin
            report_mismatch("size_in_words", out_size_in_words, want.size);
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_access(in_kind, in_offset,
                       {in_data_lane3, in_data_lane2, in_data_lane1, in_data_lane0}, fresh);
        predicted_results.push_back(fresh);
      end
      accesses_in_flight <= predicted_results.size();
    end
  end

endmodule

// File: dv/tb_top.sv
// Testbench top that drives memory accesses into the block and gives the verdict.
module tb_top;
  import vmeg_pkg::*;

  localparam int unsigned MEM_BYTES = 65536;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_kind;
  logic [OFF_W-1:0]  in_offset;
  logic [LANE_W-1:0] in_data_lane0;
  logic [LANE_W-1:0] in_data_lane1;
  logic [LANE_W-1:0] in_data_lane2;
  logic [LANE_W-1:0] in_data_lane3;
  logic              out_valid;
  logic              out_ready;
  logic              out_ok;
  logic [LANE_W-1:0] out_read_lane0;
  logic [LANE_W-1:0] out_read_lane1;
  logic [LANE_W-1:0] out_read_lane2;
  logic [LANE_W-1:0] out_read_lane3;
  logic [GAS_W-1:0]  out_expansion_gas;
  logic [SIZE_W-1:0] out_size_in_words;
  int                mismatch_total;
  int                accesses_in_flight;
  int                send_idle_pct;
  int                recv_idle_pct;
  logic [63:0]       written_offsets [$];

  vm_memory_with_expansion_gas #(.MEM_BYTES(MEM_BYTES)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_offset         (in_offset),
    .in_data_lane0     (in_data_lane0),
    .in_data_lane1     (in_data_lane1),
    .in_data_lane2     (in_data_lane2),
    .in_data_lane3     (in_data_lane3),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ok            (out_ok),
    .out_read_lane0    (out_read_lane0),
    .out_read_lane1    (out_read_lane1),
    .out_read_lane2    (out_read_lane2),
    .out_read_lane3    (out_read_lane3),
    .out_expansion_gas (out_expansion_gas),
    .out_size_in_words (out_size_in_words)
  );

  vmeg_checker #(.MEM_BYTES(MEM_BYTES)) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_offset          (in_offset),
    .in_data_lane0      (in_data_lane0),
    .in_data_lane1      (in_data_lane1),
    .in_data_lane2      (in_data_lane2),
    .in_data_lane3      (in_data_lane3),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ok             (out_ok),
    .out_read_lane0     (out_read_lane0),
    .out_read_lane1     (out_read_lane1),
    .out_read_lane2     (out_read_lane2),
    .out_read_lane3     (out_read_lane3),
    .out_expansion_gas  (out_expansion_gas),
    .out_size_in_words  (out_size_in_words),
    .mismatch_total     (mismatch_total),
    .accesses_in_flight (accesses_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_access(input kind_t kind, input logic [63:0] off,
                             input logic [63:0] d0, input logic [63:0] d1,
                             input logic [63:0] d2, input logic [63:0] d3);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_offset     <= off;
    in_data_lane0 <= d0;
    in_data_lane1 <= d1;
    in_data_lane2 <= d2;
    in_data_lane3 <= d3;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_accesses();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (accesses_in_flight == 0);
    @(posedge clk);
  endtask

  task automatic send_random(input int idx);
    kind_t       kind;
    logic [63:0] off;
    int          lim;
    int          r;
    kind = kind_t'($urandom_range(3));
    lim  = 200 + idx * 80;
    if (lim > MEM_BYTES - 1) lim = MEM_BYTES - 1;
    r = $urandom_range(99);
    if (r < 5) begin
      off = {$urandom, $urandom};
    end else if (r < 8) begin
      off = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(40);
    end else if (r < 12) begin
      kind = kind_t'({1'b1, 1'($urandom_range(1))});
      off  = MEM_BYTES - $urandom_range(31, 1);
    end else if (r < 15) begin
      off = MEM_BYTES + $urandom_range(64);
    end else if (r < 50 && written_offsets.size() > 0) begin
      off = written_offsets[$urandom_range(written_offsets.size() - 1)]
            + $urandom_range(16) - 8;
    end else begin
      off = $urandom_range(lim);
    end
    if (kind == KIND_WR_BYTE || kind == KIND_WR_WORD) begin
      written_offsets.push_back(off);
      if (written_offsets.size() > 48) void'(written_offsets.pop_front());
    end
    send_access(kind, off, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_kind       <= KIND_RD_BYTE;
    in_offset     <= '0;
    in_data_lane0 <= '0;
    in_data_lane1 <= '0;
    in_data_lane2 <= '0;
    in_data_lane3 <= '0;
    send_idle_pct = 38;
    recv_idle_pct = 82;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_access(KIND_RD_BYTE, 64'd0, '0, '0, '0, '0);
    send_access(KIND_RD_WORD, 64'd0, '0, '0, '0, '0);
    send_access(KIND_WR_WORD, 64'd5, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                64'h8899_AABB_CCDD_EEFF, 64'h0011_2233_4455_6677);
    send_access(KIND_RD_WORD, 64'd5, '0, '0, '0, '0);
    send_access(KIND_RD_WORD, 64'd0, '0, '0, '0, '0);
    send_access(KIND_RD_WORD, 64'd9, '0, '0, '0, '0);
    send_access(KIND_WR_BYTE, 64'd40, 64'hFFFF_FFFF_FFFF_FFA5, '1, '1, '1);
    send_access(KIND_RD_BYTE, 64'd40, '1, '1, '1, '1);
    send_access(KIND_WR_WORD, 64'd64, '1, '1, '1, '1);
    send_access(KIND_RD_WORD, 64'd64, '0, '0, '0, '0);
    send_access(KIND_WR_WORD, 64'd96, '0, '0, '0, '0);
    send_access(KIND_RD_WORD, 64'd80, '0, '0, '0, '0);
    send_access(KIND_RD_BYTE, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, '0, '0);
    send_access(KIND_WR_WORD, 64'hFFFF_FFFF_FFFF_FFE0, '1, '1, '1, '1);
    send_access(KIND_RD_WORD, 64'hFFFF_FFFF_FFFF_FFE1, '0, '0, '0, '0);
    send_access(KIND_RD_WORD, 64'hFFFF_FFFF_FFFF_FFDF, '0, '0, '0, '0);
    send_access(KIND_RD_BYTE, MEM_BYTES, '0, '0, '0, '0);
    send_access(KIND_WR_WORD, MEM_BYTES - 31, '1, '1, '1, '1);
    send_access(KIND_WR_BYTE, 64'd1000, 64'h0000_0000_0000_005A, '0, '0, '0);
    send_access(KIND_RD_WORD, 64'd990, '0, '0, '0, '0);
    send_access(KIND_RD_BYTE, 64'h8000_0000_0000_0000, '0, '0, '0, '0);

    for (int i = 0; i < 280; i++) send_random(i);
    drain_accesses();
    send_idle_pct = 82;
    recv_idle_pct = 38;
    for (int i = 280; i < 565; i++) send_random(i);
    drain_accesses();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 565; i < 830; i++) send_random(i);

    send_access(KIND_WR_WORD, MEM_BYTES - 32, 64'h1357_9BDF_0246_8ACE, 64'hDEAD_BEEF_0000_FFFF,
                64'hA5A5_5A5A_C3C3_3C3C, 64'h0F0F_F0F0_1234_5678);
    send_access(KIND_RD_WORD, MEM_BYTES - 32, '0, '0, '0, '0);
    send_access(KIND_WR_BYTE, MEM_BYTES - 1, '1, '0, '0, '0);
    send_access(KIND_RD_BYTE, MEM_BYTES - 1, '0, '0, '0, '0);
    send_access(KIND_RD_WORD, MEM_BYTES - 33, '0, '0, '0, '0);
    send_access(KIND_RD_WORD, MEM_BYTES - 31, '0, '0, '0, '0);

    in_valid <= 1'b0;
    @(posedge clk);
    wait (accesses_in_flight == 0);
    repeat (20) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
